// File: src/htfr_pkg.sv
// Shared types and constants of the header/tail frame receiver.
package htfr_pkg;

    localparam int RESULT_LIMIT = 64;
    localparam logic [15:0] LOW_BYTE_MASK = 16'h00ff;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] word_t;
    typedef logic [6:0]  count_t;
    typedef logic [7:0]  cfg_index_t;

    localparam cfg_index_t REG_HEADER_WORD     = 8'd0;
    localparam cfg_index_t REG_TAIL_WORD       = 8'd1;
    localparam cfg_index_t REG_FRAME_LENGTH    = 8'd2;
    localparam cfg_index_t REG_BUFFER_CAPACITY = 8'd3;

    localparam logic OUTCOME_FRAME    = 1'b0;
    localparam logic OUTCOME_OVERFLOW = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_DONE = 2'd2,
        PH_OVER = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_FETCH = 2'd1,
        BK_LOAD  = 2'd2
    } bk_state_t;

    typedef enum logic {
        CMD_FRAME    = 1'b0,
        CMD_OVERFLOW = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        count_t    len;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic has_frame;
    } q_stat_t;

endpackage

// File: src/htfr_if.sv
// Handshake channel interfaces: received bytes, results and configuration writes.
interface htfr_byte_if;
    logic               valid;
    logic               ready;
    htfr_pkg::byte_t    rx_byte;
    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

interface htfr_result_if;
    logic               valid;
    logic               ready;
    htfr_pkg::byte_t    out_byte;
    logic               outcome;
    logic               last;
    modport source(output valid, output out_byte, output outcome, output last, input ready);
    modport sink(input valid, input out_byte, input outcome, input last, output ready);
endinterface

interface htfr_cfg_if;
    logic                   valid;
    logic                   ready;
    htfr_pkg::cfg_index_t   index;
    htfr_pkg::word_t        data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// File: src/htfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module htfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/htfr_front.sv
// Front end: configuration registers, header/tail detection and frame store writes.
module htfr_front #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    htfr_cfg_if.sink                       cfg,
    htfr_byte_if.sink                      rx,
    output logic                           q_push,
    output htfr_pkg::cmd_t                 q_cmd,
    input  htfr_pkg::q_stat_t              q_stat,
    input  logic                           back_busy,
    output logic                           ram_we,
    output logic [$clog2(STORE_DEPTH)-1:0] ram_waddr,
    output htfr_pkg::byte_t                ram_wdata
);

    import htfr_pkg::*;

    localparam int ADDR_W    = $clog2(STORE_DEPTH);
    localparam int DEPTH_LIM = (STORE_DEPTH < RESULT_LIMIT) ? STORE_DEPTH : RESULT_LIMIT;

    word_t  header_reg;
    word_t  tail_reg;
    count_t frame_length_reg;
    count_t capacity_reg;

    phase_t phase_reg, phase_next;
    count_t fill_reg, fill_next;
    byte_t  prev_reg, prev_next;
    logic   pend_reg, pend_next;

    logic   rx_fire;
    logic   hdr_match;
    logic   tail_match;
    count_t fill_inc;
    count_t cap_eff;
    count_t len_eff;
    logic   in_store;
    logic   frame_done;
    logic   frame_over;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg       <= '0;
            tail_reg         <= '0;
            frame_length_reg <= 7'd4;
            capacity_reg     <= 7'd64;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_HEADER_WORD:     header_reg       <= cfg.data;
                REG_TAIL_WORD:       tail_reg         <= cfg.data;
                REG_FRAME_LENGTH:    frame_length_reg <= cfg.data[6:0];
                REG_BUFFER_CAPACITY: capacity_reg     <= cfg.data[6:0];
                default:             ;
            endcase
        end
    end

    assign rx.ready = !pend_reg && !q_stat.full && !q_stat.has_frame && !back_busy;
    assign rx_fire  = rx.valid && rx.ready;

    assign hdr_match  = (rx.rx_byte == 8'(header_reg & LOW_BYTE_MASK))
                        && (prev_reg == header_reg[15:8]);
    assign tail_match = (rx.rx_byte == 8'(tail_reg & LOW_BYTE_MASK))
                        && (prev_reg == tail_reg[15:8]);
    assign fill_inc   = fill_reg + 7'd1;
    assign cap_eff    = (capacity_reg > 7'(DEPTH_LIM)) ? 7'(DEPTH_LIM) : capacity_reg;
    assign len_eff    = (frame_length_reg > 7'(DEPTH_LIM)) ? 7'(DEPTH_LIM) : frame_length_reg;
    assign in_store   = ({1'b0, fill_reg} < 8'(STORE_DEPTH));
    assign frame_done = tail_match && (fill_inc == frame_length_reg);
    assign frame_over = (fill_inc >= cap_eff);

    always_comb
    begin
        phase_next = phase_reg;
        if (rx_fire)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (hdr_match)
                    begin
                        phase_next = PH_RECV;
                    end
                end
                PH_RECV:
                begin
                    priority if (frame_over)
                    begin
                        phase_next = PH_OVER;
                    end
                    else if (frame_done)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE, PH_OVER:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        fill_next  = fill_reg;
        prev_next  = prev_reg;
        pend_next  = 1'b0;
        q_push     = 1'b0;
        q_cmd.kind = CMD_FRAME;
        q_cmd.len  = len_eff;
        ram_we     = 1'b0;
        ram_waddr  = ADDR_W'(fill_reg);
        ram_wdata  = rx.rx_byte;
        if (pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(1);
            ram_wdata = prev_reg;
        end
        else if (rx_fire)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    prev_next = rx.rx_byte;
                    if (hdr_match)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'(0);
                        ram_wdata = prev_reg;
                        pend_next = 1'b1;
                        fill_next = 7'd2;
                    end
                end
                PH_RECV:
                begin
                    prev_next = rx.rx_byte;
                    ram_we    = in_store;
                    fill_next = fill_inc;
                end
                PH_DONE, PH_OVER:
                begin
                    q_push     = 1'b1;
                    q_cmd.kind = (phase_reg == PH_OVER) ? CMD_OVERFLOW : CMD_FRAME;
                    fill_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            fill_reg  <= '0;
            prev_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            prev_reg  <= prev_next;
            pend_reg  <= pend_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (phase_reg == PH_RECV) && (fill_reg == 7'd2))
        else $error("second header write outside reception");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 7'(RESULT_LIMIT))
        else $error("fill count beyond result limit");

endmodule

// File: src/htfr_cmd_queue.sv
// Two-entry command queue between the front end and the emitter.
module htfr_cmd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  htfr_pkg::cmd_t     push_cmd,
    input  logic               pop,
    output htfr_pkg::cmd_t     head,
    output htfr_pkg::q_stat_t  stat
);

    import htfr_pkg::*;

    cmd_t       ent_reg [2];
    logic [1:0] valid_reg, valid_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;

    assign head           = ent_reg[rd_ptr_reg];
    assign stat.full      = &valid_reg;
    assign stat.empty     = ~|valid_reg;
    assign stat.has_frame = (valid_reg[0] && (ent_reg[0].kind == CMD_FRAME))
                            || (valid_reg[1] && (ent_reg[1].kind == CMD_FRAME));

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next[rd_ptr_reg] = 1'b0;
        end
        if (push)
        begin
            valid_next[wr_ptr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full) && !(pop && stat.empty))
        else $error("queue overrun or underrun");

endmodule

// File: src/htfr_back.sv
// Back end: reads the frame store and drives the registered result word.
module htfr_back #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  htfr_pkg::cmd_t                 q_head,
    input  htfr_pkg::q_stat_t              q_stat,
    output logic                           q_pop,
    output logic                           busy,
    output logic                           ram_re,
    output logic [$clog2(STORE_DEPTH)-1:0] ram_raddr,
    input  htfr_pkg::byte_t                ram_rdata,
    htfr_result_if.source                  res
);

    import htfr_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    bk_state_t state_reg, state_next;
    count_t    idx_reg, idx_next;
    count_t    len_reg, len_next;
    logic      out_valid_reg, out_valid_next;
    byte_t     out_byte_reg, out_byte_next;
    logic      outcome_reg, outcome_next;
    logic      last_reg, last_next;

    logic      slot_free;
    logic      at_end;

    assign slot_free = !out_valid_reg || res.ready;
    assign at_end    = ((idx_reg + 7'd1) == len_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && (q_head.kind == CMD_FRAME))
                begin
                    state_next = BK_FETCH;
                end
            end
            BK_FETCH:
            begin
                state_next = BK_LOAD;
            end
            BK_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = at_end ? BK_IDLE : BK_FETCH;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = ADDR_W'(idx_reg);
        idx_next       = idx_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_byte_next  = out_byte_reg;
        outcome_next   = outcome_reg;
        last_next      = last_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    if (q_head.kind == CMD_FRAME)
                    begin
                        q_pop    = 1'b1;
                        idx_next = '0;
                        len_next = q_head.len;
                    end
                    else if (slot_free)
                    begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_byte_next  = '0;
                        outcome_next   = OUTCOME_OVERFLOW;
                        last_next      = 1'b1;
                    end
                end
            end
            BK_FETCH:
            begin
                ram_re = 1'b1;
            end
            BK_LOAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    outcome_next   = OUTCOME_FRAME;
                    last_next      = at_end;
                    idx_next       = idx_reg + 7'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            len_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        outcome_reg  <= outcome_next;
        last_reg     <= last_next;
    end

    assign busy        = (state_reg != BK_IDLE);
    assign res.valid   = out_valid_reg;
    assign res.out_byte = out_byte_reg;
    assign res.outcome = outcome_reg;
    assign res.last    = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_LOAD) |-> (idx_reg < len_reg))
        else $error("frame read index past frame length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_LOAD) |-> $past(state_reg == BK_FETCH) || $past(state_reg == BK_LOAD))
        else $error("result load without a store read");

endmodule

// File: src/header_tail_frame_receiver_core.sv
// Top level of the header/tail frame receiver.
// Flow: a complete frame is queued when the byte that follows its tail is accepted, and the back end
// then reads it out of the store through its fetch and load states into the registered result;
// an overflow result is queued likewise on the byte after the overflowing one. Rx takes one byte
// per cycle, but stalls for the second header write, a full queue, a queued frame or a busy back end.
// Reset: rst_n presets configuration, clears phase, counters, queue and output valid; store unreset.
module header_tail_frame_receiver_core #(
    parameter int STORE_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    htfr_cfg_if.sink      cfg,
    htfr_byte_if.sink     rx,
    htfr_result_if.source res
);

    import htfr_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    logic              q_push;
    logic              q_pop;
    cmd_t              push_cmd;
    cmd_t              q_head;
    q_stat_t           q_stat;
    logic              back_busy;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    byte_t             ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    byte_t             ram_rdata;

    htfr_front #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rx        (rx),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .q_stat    (q_stat),
        .back_busy (back_busy),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    htfr_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    htfr_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    htfr_back #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .busy      (back_busy),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res       (res)
    );

endmodule
